FILE: design/epq_pkg.sv
// Shared constants, types and helpers of the entry pool with linked queues.
`timescale 1ns / 1ps

package epq_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int LINK_W      = $clog2(NUM_ENTRIES + 1);
    localparam int OP_W        = 3;
    localparam int TAIL_W      = 6;
    localparam int ENT_W       = 5;
    localparam int WQ_DEPTH    = 4;
    localparam int WQ_W        = $clog2(WQ_DEPTH);

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam t_link NONE = LINK_W'(NUM_ENTRIES);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC    = 3'd0,
        OP_FREE     = 3'd1,
        OP_INSERT   = 3'd2,
        OP_REM_HEAD = 3'd3,
        OP_OUT      = 3'd4,
        OP_HEAD     = 3'd5,
        OP_INIT     = 3'd6
    } t_op;

    typedef struct packed {
        logic  en;
        logic  to_prev;
        t_idx  addr;
        t_link data;
    } t_wr;

    typedef struct packed {
        t_idx rd_addr;
        t_wr  wr;
        logic clr;
    } t_lk_cmd;

    typedef struct packed {
        t_link nxt;
        t_link prv;
    } t_lk_rd;

    typedef struct packed {
        t_op   op;
        t_link tail;
        logic  ent_ok;
        t_link ent;
    } t_req;

    typedef struct packed {
        t_link tail;
        t_link entry;
    } t_res;

    function automatic logic is_idx(t_link v);
        return v < NONE;
    endfunction

    // Build a link write; a target outside the pool is dropped.
    function automatic t_wr mk_wr(logic to_prev, t_link addr, t_link data);
        t_wr w;
        w.en      = is_idx(addr);
        w.to_prev = to_prev;
        w.addr    = addr[IDX_W-1:0];
        w.data    = data;
        return w;
    endfunction

endpackage

FILE: design/epq_if.sv
// Valid/ready channel interfaces for the request and result words.
`timescale 1ns / 1ps

interface epq_in_if;
    import epq_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TAIL_W-1:0] tail_in;
    logic [ENT_W-1:0]  entry_in;
    modport source (output valid, op, tail_in, entry_in, input ready);
    modport sink   (input valid, op, tail_in, entry_in, output ready);
endinterface

interface epq_out_if;
    import epq_pkg::*;
    logic              valid;
    logic              ready;
    logic [TAIL_W-1:0] tail_out;
    logic [TAIL_W-1:0] entry_out;
    modport source (output valid, tail_out, entry_out, input ready);
    modport sink   (input valid, tail_out, entry_out, output ready);
endinterface

FILE: design/epq_link_store.sv
// Next and prev link memories with per-entry valid bits and registered reads.
`timescale 1ns / 1ps

module epq_link_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  epq_pkg::t_lk_cmd i_cmd,
    output epq_pkg::t_lk_rd  o_rd
);
    import epq_pkg::*;

    t_link                  r_next_mem [NUM_ENTRIES];
    t_link                  r_prev_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_next_vld;
    logic [NUM_ENTRIES-1:0] r_prev_vld;
    t_link                  r_next_q;
    t_link                  r_prev_q;
    logic                   r_next_vq;
    logic                   r_prev_vq;
    t_idx                   r_addr_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr.en) begin
            if (i_cmd.wr.to_prev) begin
                r_prev_mem[i_cmd.wr.addr] <= i_cmd.wr.data;
            end else begin
                r_next_mem[i_cmd.wr.addr] <= i_cmd.wr.data;
            end
        end
        r_next_q  <= r_next_mem[i_cmd.rd_addr];
        r_prev_q  <= r_prev_mem[i_cmd.rd_addr];
        r_next_vq <= r_next_vld[i_cmd.rd_addr];
        r_prev_vq <= r_prev_vld[i_cmd.rd_addr];
        r_addr_q  <= i_cmd.rd_addr;
    end

    // An unwritten entry reads as its reset link.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_next_vld <= '0;
            r_prev_vld <= '0;
        end else if (i_cmd.wr.en) begin
            if (i_cmd.wr.to_prev) begin
                r_prev_vld[i_cmd.wr.addr] <= 1'b1;
            end else begin
                r_next_vld[i_cmd.wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rd.nxt = r_next_vq ? r_next_q : LINK_W'(r_addr_q) + LINK_W'(1);
    assign o_rd.prv = r_prev_vq ? r_prev_q : NONE;

endmodule

FILE: design/epq_ctrl.sv
// Sequencer: steps each op through reads, a list walk and queued link writes.
`timescale 1ns / 1ps

module epq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  epq_pkg::t_req    i_req,
    input  logic             i_out_free,
    input  epq_pkg::t_lk_rd  i_rd,
    output epq_pkg::t_lk_cmd o_cmd,
    output logic             o_idle,
    output logic             o_done,
    output epq_pkg::t_res    o_res
);
    import epq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_DEC  = 11'b00000000010,
        S_RD   = 11'b00000000100,
        S_USE  = 11'b00000001000,
        S_URD  = 11'b00000010000,
        S_UUSE = 11'b00000100000,
        S_WALK = 11'b00001000000,
        S_WRD  = 11'b00010000000,
        S_WUSE = 11'b00100000000,
        S_WR   = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } t_state;

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    t_link           r_tail, n_tail;
    t_link           r_ent, n_ent;
    logic            r_ent_ok, n_ent_ok;
    t_link           r_fh, n_fh;
    t_link           r_res, n_res;
    t_link           r_cur, n_cur;
    t_link           r_cnt, n_cnt;
    t_idx            r_addr, n_addr;
    t_wr             r_wq [WQ_DEPTH];
    t_wr             n_wq [WQ_DEPTH];
    logic [WQ_W-1:0] r_wi, n_wi;
    t_link           ins_link;

    // Insert links next of the new tail's prev; if the entry is the old tail
    // itself, that prev was just overwritten with the entry.
    assign ins_link = (r_tail == r_ent) ? r_ent : i_rd.prv;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_tail   = r_tail;
        n_ent    = r_ent;
        n_ent_ok = r_ent_ok;
        n_fh     = r_fh;
        n_res    = r_res;
        n_cur    = r_cur;
        n_cnt    = r_cnt;
        n_addr   = r_addr;
        n_wi     = r_wi;
        for (int k = 0; k < WQ_DEPTH; k++) begin
            n_wq[k] = r_wq[k];
        end
        o_cmd.rd_addr = r_addr;
        o_cmd.wr      = '0;
        o_cmd.clr     = 1'b0;
        o_done        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_req.op;
                    n_tail   = i_req.tail;
                    n_ent    = i_req.ent;
                    n_ent_ok = i_req.ent_ok;
                    n_res    = NONE;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                for (int k = 0; k < WQ_DEPTH; k++) begin
                    n_wq[k] = '0;
                end
                n_wi    = '0;
                n_state = S_FIN;
                case (r_op)
                    OP_ALLOC: begin
                        if (is_idx(r_fh)) begin
                            n_addr  = r_fh[IDX_W-1:0];
                            n_state = S_RD;
                        end
                    end
                    OP_FREE: begin
                        if (r_ent_ok) begin
                            n_wq[0] = mk_wr(1'b0, r_ent, r_fh);
                            n_fh    = r_ent;
                            n_state = S_WR;
                        end
                    end
                    OP_INSERT: begin
                        if (r_ent_ok) begin
                            if (r_tail == NONE) begin
                                n_wq[0] = mk_wr(1'b0, r_ent, r_ent);
                                n_wq[1] = mk_wr(1'b1, r_ent, r_ent);
                                n_tail  = r_ent;
                                n_state = S_WR;
                            end else begin
                                n_addr  = r_tail[IDX_W-1:0];
                                n_state = S_RD;
                            end
                        end
                    end
                    OP_REM_HEAD, OP_HEAD: begin
                        if (r_tail != NONE) begin
                            n_addr  = r_tail[IDX_W-1:0];
                            n_state = S_RD;
                        end
                    end
                    OP_OUT: begin
                        if (r_tail != NONE && r_ent_ok) begin
                            n_cur   = r_tail;
                            n_cnt   = '0;
                            n_state = S_WALK;
                        end
                    end
                    OP_INIT: begin
                        o_cmd.clr = 1'b1;
                        n_fh      = '0;
                        n_tail    = NONE;
                    end
                    default: begin
                    end
                endcase
            end
            S_RD: begin
                n_state = S_USE;
            end
            S_USE: begin
                n_state = S_FIN;
                case (r_op)
                    OP_ALLOC: begin
                        n_res   = r_fh;
                        n_fh    = i_rd.nxt;
                        n_wq[0] = mk_wr(1'b0, r_fh, NONE);
                        n_wq[1] = mk_wr(1'b1, r_fh, NONE);
                        n_state = S_WR;
                    end
                    OP_INSERT: begin
                        n_wq[0] = mk_wr(1'b0, r_ent, r_tail);
                        n_wq[1] = mk_wr(1'b1, r_ent, i_rd.prv);
                        n_wq[2] = mk_wr(1'b1, r_tail, r_ent);
                        n_wq[3] = mk_wr(1'b0, ins_link, r_ent);
                        n_tail  = r_ent;
                        n_state = S_WR;
                    end
                    OP_REM_HEAD: begin
                        if (is_idx(i_rd.prv)) begin
                            n_res = i_rd.prv;
                            if (i_rd.prv == r_tail) begin
                                n_tail = NONE;
                            end else begin
                                n_addr  = i_rd.prv[IDX_W-1:0];
                                n_state = S_URD;
                            end
                        end
                    end
                    OP_HEAD: begin
                        n_res = is_idx(i_rd.prv) ? i_rd.prv : NONE;
                    end
                    default: begin
                    end
                endcase
            end
            S_URD: begin
                n_state = S_UUSE;
            end
            S_UUSE: begin
                // unlink: next of prev gets next, prev of next gets prev
                n_wq[0] = mk_wr(1'b0, i_rd.prv, i_rd.nxt);
                n_wq[1] = mk_wr(1'b1, i_rd.nxt, i_rd.prv);
                n_state = S_WR;
                if (r_op == OP_OUT) begin
                    n_res = r_ent;
                    if (r_cur == r_tail) begin
                        if (i_rd.nxt == r_cur) begin
                            n_tail  = NONE;
                            n_wq[0] = '0;
                            n_wq[1] = '0;
                        end else begin
                            n_tail = is_idx(i_rd.nxt) ? i_rd.nxt : NONE;
                        end
                    end
                end
            end
            S_WALK: begin
                if (r_cnt == LINK_W'(NUM_ENTRIES) || !is_idx(r_cur)) begin
                    n_state = S_FIN;
                end else begin
                    n_addr  = r_cur[IDX_W-1:0];
                    n_state = (r_cur == r_ent) ? S_URD : S_WRD;
                end
            end
            S_WRD: begin
                n_state = S_WUSE;
            end
            S_WUSE: begin
                n_cur   = i_rd.nxt;
                n_cnt   = r_cnt + LINK_W'(1);
                n_state = (i_rd.nxt == r_tail) ? S_FIN : S_WALK;
            end
            S_WR: begin
                o_cmd.wr = r_wq[r_wi];
                n_wi     = r_wi + WQ_W'(1);
                if (r_wi == WQ_W'(WQ_DEPTH - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fh    <= '0;
        end else begin
            r_state <= n_state;
            r_fh    <= n_fh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_tail   <= n_tail;
        r_ent    <= n_ent;
        r_ent_ok <= n_ent_ok;
        r_res    <= n_res;
        r_cur    <= n_cur;
        r_cnt    <= n_cnt;
        r_addr   <= n_addr;
        r_wi     <= n_wi;
        for (int k = 0; k < WQ_DEPTH; k++) begin
            r_wq[k] <= n_wq[k];
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res.tail  = r_tail;
    assign o_res.entry = r_res;

endmodule

FILE: design/entry_pool_with_linked_queues.sv
// Entry pool with a free list and circular doubly linked queues.
//
// Request channel i_in carries op, tail_in and entry_in; result channel o_out
// returns tail_out and entry_out, one result word for every request word.
// The caller keeps each queue's tail handle and passes it in with every op;
// the code NUM_ENTRIES (32) means an empty queue or no entry.
// One request is worked at a time; ready stays low from acceptance until its
// result is loaded into the output register. All link traffic goes through
// one read and one write port of the link store, under a small sequencer.
// Out walks the queue from its tail with one link read per visited entry and
// stops after NUM_ENTRIES entries, at a none link or back at the tail.
// The output register lets a new request in while a result waits; a stalled
// receiver only holds back the next result, not the work on the request.
// Reset (and the init op) returns every link to its reset value at once
// through per-entry valid bits, so no clearing pass follows reset.
`timescale 1ns / 1ps

module entry_pool_with_linked_queues (
    input logic        i_clk,
    input logic        i_rst_n,
    epq_in_if.sink     i_in,
    epq_out_if.source  o_out
);
    import epq_pkg::*;

    t_req    req;
    t_res    res;
    t_lk_cmd cmd;
    t_lk_rd  rd;
    logic    start;
    logic    idle;
    logic    done;
    logic    out_free;
    logic    r_o_vld;
    t_res    r_o_data;

    assign i_in.ready = idle;
    assign start      = i_in.valid && idle;

    // Out-of-range tails are an empty queue.
    assign req.op     = t_op'(i_in.op);
    assign req.tail   = (32'(i_in.tail_in) >= NUM_ENTRIES) ? NONE : LINK_W'(i_in.tail_in);
    assign req.ent_ok = 32'(i_in.entry_in) < NUM_ENTRIES;
    assign req.ent    = LINK_W'(i_in.entry_in);

    assign out_free = !r_o_vld || o_out.ready;

    epq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (req),
        .i_out_free (out_free),
        .i_rd       (rd),
        .o_cmd      (cmd),
        .o_idle     (idle),
        .o_done     (done),
        .o_res      (res)
    );

    epq_link_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rd    (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (done) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_o_data <= res;
        end
    end

    assign o_out.valid     = r_o_vld;
    assign o_out.tail_out  = TAIL_W'(r_o_data.tail);
    assign o_out.entry_out = TAIL_W'(r_o_data.entry);

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) start |=> !i_in.ready
    ) else $error("request taken while a request is in work");

    a_done_into_free_reg: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) done |-> out_free
    ) else $error("result loaded over an untaken result word");

    a_idle_after_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) done |=> i_in.ready
    ) else $error("sequencer not idle after finishing");

    a_result_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_data.tail <= NONE && r_o_data.entry <= NONE)
    ) else $error("result handle outside the pool");

endmodule

FILE: bench/entry_pool_with_linked_queues_tb.sv
// Self-checking testbench for the entry pool with a free list and linked queues.
`timescale 1ns / 1ps

import epq_pkg::*;

class epq_pool_scoreboard;
    t_link nxt_lk [NUM_ENTRIES];
    t_link prv_lk [NUM_ENTRIES];
    t_link free_top;
    t_res  queued_replies[$];
    int    mismatches;

    function new();
        mismatches = 0;
        restore_pool();
    endfunction

    function void restore_pool();
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            nxt_lk[i] = t_link'(i + 1);
            prv_lk[i] = NONE;
        end
        free_top = '0;
    endfunction

    // Link accesses outside the pool read as none and drop their writes.
    function t_link rd_nxt(t_link i);
        return (i < NONE) ? nxt_lk[i[IDX_W-1:0]] : NONE;
    endfunction

    function t_link rd_prv(t_link i);
        return (i < NONE) ? prv_lk[i[IDX_W-1:0]] : NONE;
    endfunction

    function void wr_nxt(t_link i, t_link v);
        if (i < NONE) nxt_lk[i[IDX_W-1:0]] = v;
    endfunction

    function void wr_prv(t_link i, t_link v);
        if (i < NONE) prv_lk[i[IDX_W-1:0]] = v;
    endfunction

    function void unlink(t_link e);
        t_link n;
        t_link p;
        n = rd_nxt(e);
        p = rd_prv(e);
        wr_nxt(p, n);
        wr_prv(n, p);
    endfunction

    // Apply one accepted request word and queue the reply it must produce.
    function t_res note_request(logic [OP_W-1:0] op, logic [TAIL_W-1:0] tail_in,
                                logic [ENT_W-1:0] ent_in);
        t_link tl;
        t_link ent;
        t_link cur;
        t_link hd;
        t_res  r;
        ent     = t_link'(ent_in);
        tl      = (tail_in < NUM_ENTRIES) ? t_link'(tail_in) : NONE;
        r.entry = NONE;
        case (op)
            OP_ALLOC: begin
                if (free_top < NONE) begin
                    r.entry = free_top;
                    free_top = nxt_lk[free_top[IDX_W-1:0]];
                    nxt_lk[r.entry[IDX_W-1:0]] = NONE;
                    prv_lk[r.entry[IDX_W-1:0]] = NONE;
                end
            end
            OP_FREE: begin
                nxt_lk[ent_in] = free_top;
                free_top = ent;
            end
            OP_INSERT: begin
                if (tl == NONE) begin
                    nxt_lk[ent_in] = ent;
                    prv_lk[ent_in] = ent;
                end else begin
                    nxt_lk[ent_in] = tl;
                    prv_lk[ent_in] = rd_prv(tl);
                    wr_prv(tl, ent);
                    wr_nxt(prv_lk[ent_in], ent);
                end
                tl = ent;
            end
            OP_REM_HEAD: begin
                if (tl != NONE) begin
                    hd = rd_prv(tl);
                    if (hd < NONE) begin
                        r.entry = hd;
                        if (hd == tl) tl = NONE;
                        else unlink(hd);
                    end
                end
            end
            OP_OUT: begin
                if (tl != NONE) begin
                    cur = tl;
                    // walk at most one lap; a none link ends the search
                    for (int k = 0; k < NUM_ENTRIES && cur < NONE; k++) begin
                        if (cur == ent) begin
                            if (cur == tl) begin
                                if (rd_nxt(cur) == cur) begin
                                    tl = NONE;
                                end else begin
                                    unlink(cur);
                                    tl = rd_nxt(cur);
                                    if (tl > NONE) tl = NONE;
                                end
                            end else begin
                                unlink(cur);
                            end
                            r.entry = ent;
                            break;
                        end
                        cur = rd_nxt(cur);
                        if (cur == tl) break;
                    end
                end
            end
            OP_HEAD: begin
                if (tl != NONE) begin
                    r.entry = rd_prv(tl);
                    if (r.entry > NONE) r.entry = NONE;
                end
            end
            OP_INIT: begin
                restore_pool();
                tl = NONE;
            end
            default: ;
        endcase
        r.tail = tl;
        queued_replies.push_back(r);
        return r;
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_result(logic [TAIL_W-1:0] tail_o, logic [TAIL_W-1:0] entry_o);
        t_res want;
        if (queued_replies.size() == 0) begin
            flag($sformatf("result word with nothing pending: tail_out %0d entry_out %0d",
                           tail_o, entry_o));
            return;
        end
        want = queued_replies.pop_front();
        if (tail_o !== want.tail)
            flag($sformatf("tail_out expected %0d, got %0d", want.tail, tail_o));
        if (entry_o !== want.entry)
            flag($sformatf("entry_out expected %0d, got %0d", want.entry, entry_o));
    endfunction
endclass

module entry_pool_with_linked_queues_tb;

    localparam int                CLK_HALF      = 5;
    localparam int                RANDOM_ITEMS  = 926;
    localparam int                NUM_QUEUES    = 4;
    localparam int                NO_QUEUE      = -1;
    localparam int                IDLE_PCT      = 19;
    localparam int                HOLD_CYCLES   = 64;
    localparam int                HOLD_AT       = 350;
    localparam int                DRAIN_AT      = 500;
    localparam int                CALM_FROM     = 600;
    localparam int                CALM_TO       = 760;
    localparam int                INIT_EVERY    = 64;
    localparam int                SETTLE_CYCLES = 3 * NUM_ENTRIES + 20;
    localparam int                STALL_LIMIT   = 2000;
    localparam logic [OP_W-1:0]   OP_UNUSED     = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n;
    logic calm     = 1'b0;
    logic hold_req = 1'b0;
    int   stall_cycles = 0;

    epq_in_if  in_ch ();
    epq_out_if out_ch ();

    entry_pool_with_linked_queues u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    epq_pool_scoreboard sb = new();

    // caller-side view of the pool: allocated loose entries and queue contents
    int    loose[$];
    int    members[NUM_QUEUES][$];
    t_link tails[NUM_QUEUES];

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    function automatic int find_pos(int lst[$], int v);
        foreach (lst[i]) if (lst[i] == v) return i;
        return -1;
    endfunction

    function automatic void forget_all();
        loose.delete();
        for (int i = 0; i < NUM_QUEUES; i++) begin
            members[i].delete();
            tails[i] = NONE;
        end
    endfunction

    // Present one word, hold it until accepted, then update the caller view.
    task automatic issue(input logic [OP_W-1:0] op, input logic [TAIL_W-1:0] tl,
                         input logic [ENT_W-1:0] ent, input int q, output t_res r);
        int pos;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.tail_in  <= tl;
        in_ch.entry_in <= ent;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        r = sb.note_request(op, tl, ent);
        if (op == OP_INIT) begin
            forget_all();
        end else if (op == OP_ALLOC) begin
            if (r.entry != NONE) loose.push_back(r.entry);
        end else if (q != NO_QUEUE) begin
            case (op)
                OP_FREE: begin
                    pos = find_pos(loose, ent);
                    if (pos >= 0) loose.delete(pos);
                end
                OP_INSERT: begin
                    pos = find_pos(loose, ent);
                    if (pos >= 0) loose.delete(pos);
                    members[q].push_back(ent);
                    tails[q] = r.tail;
                end
                OP_REM_HEAD, OP_OUT: begin
                    tails[q] = r.tail;
                    if (r.entry != NONE) begin
                        pos = find_pos(members[q], r.entry);
                        if (pos >= 0) members[q].delete(pos);
                        loose.push_back(r.entry);
                    end
                end
                default: ;
            endcase
        end
    endtask

    // Drop valid and wait for every pending reply.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.queued_replies.size() != 0);
    endtask

    // Mostly well-formed queue traffic, some raw words mixed in.
    function automatic void pick(input int n, output logic [OP_W-1:0] op,
                                 output logic [TAIL_W-1:0] tl,
                                 output logic [ENT_W-1:0] ent, output int q);
        int r;
        r   = $urandom_range(0, 99);
        q   = $urandom_range(0, NUM_QUEUES - 1);
        tl  = tails[q];
        ent = ENT_W'($urandom);
        if (n % INIT_EVERY == INIT_EVERY - 1 || r < 1) begin
            op = OP_INIT;
        end else if (r < 5) begin
            op = OP_W'($urandom_range(0, 7));
            tl = TAIL_W'($urandom_range(0, 63));
            q  = NO_QUEUE;
        end else if (r < 25 || (r < 63 && loose.size() == 0)) begin
            op = OP_ALLOC;
        end else if (r < 38) begin
            op  = OP_FREE;
            ent = ENT_W'(loose[$urandom_range(0, loose.size() - 1)]);
        end else if (r < 63) begin
            op  = OP_INSERT;
            ent = ENT_W'(loose[$urandom_range(0, loose.size() - 1)]);
        end else if (r < 76) begin
            op = OP_REM_HEAD;
        end else if (r < 90) begin
            op = OP_OUT;
            if (members[q].size() != 0 && $urandom_range(0, 99) < 80)
                ent = ENT_W'(members[q][$urandom_range(0, members[q].size() - 1)]);
        end else begin
            op = OP_HEAD;
        end
    endfunction

    initial begin : driver
        t_res              r;
        t_link             t;
        logic [OP_W-1:0]   op;
        logic [TAIL_W-1:0] tl;
        logic [ENT_W-1:0]  ent;
        int                q;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.op       = '0;
        in_ch.tail_in  = '0;
        in_ch.entry_in = '0;
        forget_all();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue queries, then a small three-entry queue
        issue(OP_HEAD, NONE, '0, NO_QUEUE, r);
        issue(OP_REM_HEAD, NONE, '1, NO_QUEUE, r);
        repeat (3) issue(OP_ALLOC, '0, '0, NO_QUEUE, r);
        t = NONE;
        for (int e = 0; e < 3; e++) begin
            issue(OP_INSERT, t, ENT_W'(e), NO_QUEUE, r);
            t = r.tail;
        end
        issue(OP_HEAD, t, '0, NO_QUEUE, r);
        // absent entry, middle entry, then the tail itself
        issue(OP_OUT, t, 5'd31, NO_QUEUE, r);
        issue(OP_OUT, t, 5'd1, NO_QUEUE, r);
        issue(OP_OUT, t, t[ENT_W-1:0], NO_QUEUE, r);
        t = r.tail;
        // head equal to tail empties the queue
        issue(OP_REM_HEAD, t, '0, NO_QUEUE, r);
        issue(OP_INSERT, r.tail, 5'd0, NO_QUEUE, r);
        issue(OP_OUT, r.tail, 5'd0, NO_QUEUE, r);
        // tail handles past the pool count as an empty queue; then an unused op code
        issue(OP_HEAD, 6'd63, 5'd31, NO_QUEUE, r);
        issue(OP_INSERT, 6'd45, 5'd1, NO_QUEUE, r);
        issue(OP_UNUSED, 6'd17, 5'd5, NO_QUEUE, r);
        // double free corrupts the free list until it runs dry
        issue(OP_FREE, NONE, 5'd2, NO_QUEUE, r);
        issue(OP_FREE, NONE, 5'd2, NO_QUEUE, r);
        repeat (3) issue(OP_ALLOC, 6'd31, '0, NO_QUEUE, r);
        issue(OP_INIT, 6'd5, 5'd31, NO_QUEUE, r);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) hold_req <= 1'b1;
            if (n == CALM_FROM) calm <= 1'b1;
            if (n == CALM_TO) calm <= 1'b0;
            if (n == DRAIN_AT) drain();
            pick(n, op, tl, ent, q);
            issue(op, tl, ent, q, r);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.queued_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : receiver
        logic hold_done;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            // one long hold-off lets the block fill up and stall its input
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_result(out_ch.tail_out, out_ch.entry_out);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
